@@ rtl/core/dvm_pkg.sv @@
// Shared widths, register indexes, configuration record and divider constants
// for the differential drive velocity mixer. No dependencies.
package dvm_pkg;

    localparam int VEL_W      = 19;   // velocity fields, signed
    localparam int MV_W       = 18;   // millivolt results, signed
    localparam int MAX_W      = 10;   // top speed register
    localparam int FRAC_W     = 17;   // Q1.16 fraction registers
    localparam int STEP_W     = FRAC_W + MAX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TOP_RPM     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ENABLE  = 3'd4;

    localparam logic [MAX_W-1:0]  TOP_RPM_RST = 10'd200;
    localparam logic [FRAC_W-1:0] FRAC_ONE    = 17'd65536;

    // Voltage conversion: rpm * 12000 / 127
    localparam int MUL_A_W = VEL_W + 1;
    localparam int MUL_B_W = 24;
    localparam int NUM_W   = MUL_A_W + MUL_B_W;
    localparam int DEN_W   = 27;
    localparam logic [MUL_B_W-1:0] MV_SCALE = 24'd12000;
    localparam logic [DEN_W-1:0]   MV_DIV   = 27'd127;

    localparam logic signed [MV_W-1:0] MV_MAX = 18'sd131071;
    localparam logic signed [MV_W-1:0] MV_MIN = -18'sd131072;

    // Quotient bits produced by the divider; the top bit flags saturation
    localparam int DIV_STEPS = MV_W;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic [MAX_W-1:0]  top_rpm;
        logic [FRAC_W-1:0] drive_limit_fraction;
        logic [FRAC_W-1:0] turn_limit_fraction;
        logic [FRAC_W-1:0] accel_fraction;
        logic              outputs_enabled;
    } t_cfg;

endpackage

@@ rtl/core/dvm_ifs.sv @@
// Valid/ready channel interfaces of the mixer: command input, voltage result
// and configuration write. Depends on dvm_pkg.
interface dvm_in_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic signed [dvm_pkg::VEL_W-1:0]   commanded_velocity;
    logic signed [dvm_pkg::VEL_W-1:0]   measured_left_velocity;
    logic signed [dvm_pkg::VEL_W-1:0]   measured_right_velocity;

    modport source (output valid, kind, commanded_velocity, measured_left_velocity,
                    measured_right_velocity, input ready);
    modport sink (input valid, kind, commanded_velocity, measured_left_velocity,
                  measured_right_velocity, output ready);
endinterface

interface dvm_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [dvm_pkg::MV_W-1:0]  left_millivolts;
    logic signed [dvm_pkg::MV_W-1:0]  right_millivolts;

    modport source (output valid, left_millivolts, right_millivolts, input ready);
    modport sink (input valid, left_millivolts, right_millivolts, output ready);
endinterface

interface dvm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dvm_pkg::CFG_IDX_W-1:0]     index;
    logic [dvm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/diff_drive_velocity_mixer_top.sv @@
// Differential drive velocity mixer: step limit, percent clamps, arcade mixing,
// normalisation and millivolt conversion. Depends on dvm_pkg, dvm_ifs, dvm_cfg, dvm_div.
// One item at a time: a command is accepted only in the idle state, and the result lands in
// the output register after ten set-up steps, two passes of the shared divider and the output
// step, which waits while a held result is not yet taken; the sequencer then returns to idle.
// Reset (synchronous, active low) clears held drive and turn commands, sequencer and output valid.
module diff_drive_velocity_mixer_top #(
    parameter int VELOCITY_FRAC_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dvm_in_if.sink    i_cmd,
    dvm_cfg_if.sink   i_cfg,
    dvm_out_if.source o_res
);

    localparam int F     = VELOCITY_FRAC_BITS;
    localparam int VW    = dvm_pkg::VEL_W;
    localparam int MIX_W = VW + 1;
    localparam int SW    = dvm_pkg::STEP_W;
    localparam int DB_W  = ((MIX_W + 16 > SW + F + 1) ? MIX_W + 16 : SW + F + 1) + 1;
    localparam int CB_W  = (VW + 16 > SW + F) ? VW + 16 : SW + F;
    localparam int SM_W  = (MIX_W > dvm_pkg::MAX_W + F) ? MIX_W : dvm_pkg::MAX_W + F;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_STEP = 4'd1;
    localparam logic [3:0] ST_DLIM = 4'd2;
    localparam logic [3:0] ST_DFR  = 4'd3;
    localparam logic [3:0] ST_DCL  = 4'd4;
    localparam logic [3:0] ST_TFR  = 4'd5;
    localparam logic [3:0] ST_TCL  = 4'd6;
    localparam logic [3:0] ST_MIX  = 4'd7;
    localparam logic [3:0] ST_MAG  = 4'd8;
    localparam logic [3:0] ST_KDEN = 4'd9;
    localparam logic [3:0] ST_NUML = 4'd10;
    localparam logic [3:0] ST_DIVL = 4'd11;
    localparam logic [3:0] ST_NUMR = 4'd12;
    localparam logic [3:0] ST_DIVR = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;

    function automatic logic [VW-1:0] vel_mag(input logic signed [VW-1:0] v);
        vel_mag = v[VW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [MIX_W-1:0] mix_mag(input logic signed [MIX_W-1:0] v);
        mix_mag = v[MIX_W-1] ? (~v + 1'b1) : v;
    endfunction

    dvm_pkg::t_cfg cfg;

    logic [3:0]                       r_state, n_state;
    logic                             r_kind;
    logic signed [VW-1:0]             r_cmd;
    logic signed [VW-1:0]             r_ml;
    logic signed [VW-1:0]             r_mr;
    logic [MIX_W-1:0]                 r_msum;
    logic [dvm_pkg::NUM_W-1:0]        r_prod;
    logic signed [VW-1:0]             r_drive;
    logic signed [VW-1:0]             r_turn;
    logic signed [VW-1:0]             r_d;
    logic signed [VW-1:0]             r_t;
    logic signed [MIX_W-1:0]          r_l;
    logic signed [MIX_W-1:0]          r_r;
    logic [MIX_W-1:0]                 r_m;
    logic                             r_scale;
    logic [dvm_pkg::DEN_W-1:0]        r_den;
    logic [dvm_pkg::MUL_B_W-1:0]      r_k;
    logic signed [dvm_pkg::MV_W-1:0]  r_lmv;
    logic                             r_out_valid;
    logic signed [dvm_pkg::MV_W-1:0]  r_out_l;
    logic signed [dvm_pkg::MV_W-1:0]  r_out_r;

    logic [dvm_pkg::MUL_A_W-1:0]      mul_a;
    logic [dvm_pkg::MUL_B_W-1:0]      mul_b;
    logic [dvm_pkg::NUM_W-1:0]        mul_p;
    logic signed [MIX_W-1:0]          msum_s;
    logic [DB_W-1:0]                  db_bound;
    logic [DB_W-1:0]                  db_cmd;
    logic [VW-1:0]                    db_lim;
    logic signed [VW-1:0]             cl_v;
    logic [CB_W-1:0]                  cl_bound;
    logic [CB_W-1:0]                  cl_a;
    logic [VW-1:0]                    cl_lim;
    logic signed [VW-1:0]             cl_out;
    logic [MIX_W-1:0]                 al, ar, m_next;
    logic                             div_start;
    logic                             div_done;
    logic [dvm_pkg::DIV_STEPS-1:0]    div_quo;
    logic                             res_neg;
    logic signed [dvm_pkg::MV_W-1:0]  q_s;
    logic signed [dvm_pkg::MV_W-1:0]  mv;
    logic                             out_load;

    dvm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    dvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mul_p),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign i_cmd.ready            = (r_state == ST_IDLE);
    assign o_res.valid            = r_out_valid;
    assign o_res.left_millivolts  = r_out_l;
    assign o_res.right_millivolts = r_out_r;

    // Shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_STEP: begin
                mul_a = dvm_pkg::MUL_A_W'(cfg.accel_fraction);
                mul_b = dvm_pkg::MUL_B_W'(cfg.top_rpm);
            end
            ST_DFR: begin
                mul_a = dvm_pkg::MUL_A_W'(cfg.drive_limit_fraction);
                mul_b = dvm_pkg::MUL_B_W'(cfg.top_rpm);
            end
            ST_TFR: begin
                mul_a = dvm_pkg::MUL_A_W'(cfg.turn_limit_fraction);
                mul_b = dvm_pkg::MUL_B_W'(cfg.top_rpm);
            end
            ST_KDEN: begin
                mul_a = r_scale ? dvm_pkg::MUL_A_W'(cfg.top_rpm) : dvm_pkg::MUL_A_W'(1);
                mul_b = dvm_pkg::MV_SCALE;
            end
            ST_NUML: begin
                mul_a = mix_mag(r_l);
                mul_b = r_k;
            end
            ST_NUMR: begin
                mul_a = mix_mag(r_r);
                mul_b = r_k;
            end
            default: ;
        endcase
    end

    assign mul_p = dvm_pkg::NUM_W'(mul_a) * dvm_pkg::NUM_W'(mul_b);

    assign msum_s = MIX_W'(r_ml) + MIX_W'(r_mr);

    // Drive step bound at scale 2^(F+17)
    assign db_bound = (DB_W'(r_msum) << 16) + (DB_W'(r_prod[SW-1:0]) << (F + 1));
    assign db_cmd   = DB_W'(vel_mag(r_cmd)) << 17;
    assign db_lim   = db_bound[17 +: VW];

    // Percent clamp at scale 2^(F+16), shared by drive and turn
    assign cl_v     = (r_state == ST_DCL) ? r_drive : r_turn;
    assign cl_bound = CB_W'(r_prod[SW-1:0]) << F;
    assign cl_a     = CB_W'(vel_mag(cl_v)) << 16;
    assign cl_lim   = cl_bound[16 +: VW];
    assign cl_out   = (cl_a > cl_bound) ? (cl_v[VW-1] ? -$signed(cl_lim) : $signed(cl_lim))
                                        : cl_v;

    assign al     = mix_mag(r_l);
    assign ar     = mix_mag(r_r);
    assign m_next = (al > ar) ? al : ar;

    assign div_start = (r_state == ST_NUML) || (r_state == ST_NUMR);

    // Apply the side's sign to the magnitude quotient and saturate
    assign res_neg = (r_state == ST_DIVL) ? r_l[MIX_W-1] : r_r[MIX_W-1];
    assign q_s     = $signed({1'b0, div_quo[dvm_pkg::DIV_STEPS-2:0]});
    always_comb begin
        if (div_quo[dvm_pkg::DIV_STEPS-1]) begin
            mv = res_neg ? dvm_pkg::MV_MIN : dvm_pkg::MV_MAX;
        end else begin
            mv = res_neg ? -q_s : q_s;
        end
    end

    assign out_load = (r_state == ST_OUT) && cfg.outputs_enabled &&
                      (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_cmd.valid) n_state = ST_STEP;
            ST_STEP: n_state = ST_DLIM;
            ST_DLIM: n_state = ST_DFR;
            ST_DFR:  n_state = ST_DCL;
            ST_DCL:  n_state = ST_TFR;
            ST_TFR:  n_state = ST_TCL;
            ST_TCL:  n_state = ST_MIX;
            ST_MIX:  n_state = ST_MAG;
            ST_MAG:  n_state = ST_KDEN;
            ST_KDEN: n_state = ST_NUML;
            ST_NUML: n_state = ST_DIVL;
            ST_DIVL: if (div_done) n_state = ST_NUMR;
            ST_NUMR: n_state = ST_DIVR;
            ST_DIVR: if (div_done) n_state = ST_OUT;
            ST_OUT: begin
                // drop the result when outputs are disabled
                if (!cfg.outputs_enabled || out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_drive     <= '0;
            r_turn      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DLIM) begin
                if (!r_kind) begin
                    if (db_cmd > db_bound) begin
                        r_drive <= r_cmd[VW-1] ? -$signed(db_lim) : $signed(db_lim);
                    end else begin
                        r_drive <= r_cmd;
                    end
                end else begin
                    r_turn <= r_cmd;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd.valid) begin
            r_kind <= i_cmd.kind;
            r_cmd  <= i_cmd.commanded_velocity;
            r_ml   <= i_cmd.measured_left_velocity;
            r_mr   <= i_cmd.measured_right_velocity;
        end
        case (r_state) inside
            ST_STEP: begin
                r_prod <= mul_p;
                r_msum <= mix_mag(msum_s);
            end
            ST_DFR, ST_TFR: r_prod <= mul_p;
            ST_DCL: r_d <= cl_out;
            ST_TCL: r_t <= cl_out;
            ST_MIX: begin
                r_l <= MIX_W'(r_d) + MIX_W'(r_t);
                r_r <= MIX_W'(r_d) - MIX_W'(r_t);
            end
            ST_MAG: begin
                r_m     <= m_next;
                r_scale <= SM_W'(m_next) > (SM_W'(cfg.top_rpm) << F);
            end
            ST_KDEN: begin
                r_k   <= mul_p[dvm_pkg::MUL_B_W-1:0];
                r_den <= r_scale ? ((dvm_pkg::DEN_W'(r_m) << 7) - dvm_pkg::DEN_W'(r_m))
                                 : (dvm_pkg::MV_DIV << F);
            end
            ST_DIVL: if (div_done) r_lmv <= mv;
            default: ;
        endcase
        // the divider holds the right quotient while the result waits here
        if (out_load) begin
            r_out_l <= r_lmv;
            r_out_r <= mv;
        end
    end

endmodule

@@ rtl/core/dvm_cfg.sv @@
// Configuration register file of the mixer, written over its own channel.
// Depends on dvm_pkg and dvm_ifs.
module dvm_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dvm_cfg_if.sink       i_cfg,
    output dvm_pkg::t_cfg o_cfg
);

    dvm_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top_rpm              <= dvm_pkg::TOP_RPM_RST;
            r_cfg.drive_limit_fraction <= dvm_pkg::FRAC_ONE;
            r_cfg.turn_limit_fraction  <= dvm_pkg::FRAC_ONE;
            r_cfg.accel_fraction       <= dvm_pkg::FRAC_ONE;
            r_cfg.outputs_enabled      <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dvm_pkg::REG_TOP_RPM:     r_cfg.top_rpm <= i_cfg.data[dvm_pkg::MAX_W-1:0];
                dvm_pkg::REG_DRIVE_LIMIT: r_cfg.drive_limit_fraction <= i_cfg.data;
                dvm_pkg::REG_TURN_LIMIT:  r_cfg.turn_limit_fraction <= i_cfg.data;
                dvm_pkg::REG_ACCEL:       r_cfg.accel_fraction <= i_cfg.data;
                dvm_pkg::REG_OUT_ENABLE:  r_cfg.outputs_enabled <= i_cfg.data[0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

endmodule

@@ rtl/core/dvm_div.sv @@
// Restoring divider, one quotient bit a cycle, shared by both motor sides.
// The top quotient bit set means the quotient overflows the result range.
// Depends on dvm_pkg.
module dvm_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [dvm_pkg::NUM_W-1:0]         i_num,
    input  logic [dvm_pkg::DEN_W-1:0]         i_den,
    output logic                              o_done,
    output logic [dvm_pkg::DIV_STEPS-1:0]     o_quo
);

    logic                            r_busy;
    logic                            r_done;
    logic [dvm_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [dvm_pkg::NUM_W-1:0]       r_rem;
    logic [dvm_pkg::NUM_W-1:0]       r_dsh;
    logic [dvm_pkg::DIV_STEPS-1:0]   r_quo;
    logic                            ge;

    assign ge     = (r_rem >= r_dsh);
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dvm_pkg::DIV_CNT_W'(dvm_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= dvm_pkg::NUM_W'(i_den) << (dvm_pkg::DIV_STEPS - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[dvm_pkg::DIV_STEPS-2:0], ge};
        end
    end

endmodule
